FILE: design/mxfp8_block_quantizer_macros.svh
// assertion macros for the mxfp8 block quantiser checker
// no dependencies
`ifndef MXFP8_BLOCK_QUANTIZER_MACROS_SVH
`define MXFP8_BLOCK_QUANTIZER_MACROS_SVH
// implication checked on every clock edge outside reset
`define MXQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// implication with the consequent checked in the cycle after the antecedent
`define MXQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

FILE: design/mxq_pkg.sv
// shared constants and the e4m3 conversion function for the mxfp8 block quantiser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mxq_pkg;
	localparam int BLOCK_SIZE_DEF = 32;
	localparam logic [7:0] E4M3_MAX = 8'h7E;
	localparam logic [7:0] SCALE_MAX = 8'd254;

	// quantise one bf16 value with shared exponent e8 (exact power-of-two scaling)
	function automatic logic [7:0] quantise(input logic [15:0] v, input logic [7:0] e8);
		logic sgn;
		logic [7:0] ex;
		logic [6:0] man;
		logic signed [10:0] ue;
		logic signed [10:0] ne;
		logic [7:0] sig;
		logic [7:0] nsig;
		logic [10:0] sh;
		logic [22:0] wide;
		logic [22:0] rem;
		logic [22:0] half;
		logic [7:0] code;
		logic [3:0] rm;
		logic [8:0] nc;
		sgn = v[15];
		ex = v[14:7];
		man = v[6:0];
		code = 8'd0;
		if (v[14:0] > 15'h7F80) begin
			quantise = E4M3_MAX;
		end else if (ex == 8'hFF) begin
			quantise = {sgn, E4M3_MAX[6:0]};
		end else begin
			// product exponent (unbiased): ex - e8, subnormal input behaves as exponent 1
			sig = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};
			ue = $signed({3'b000, (ex == 8'd0) ? 8'd1 : ex}) - $signed({3'b000, e8});
			// e8 == 254 scale is 2^127, identical exponent shift
			// normalise so the leading one sits in the top bit
			nsig = sig;
			ne = ue;
			for (int i = 0; i < 7; i++) begin
				if (!nsig[7]) begin
					nsig = {nsig[6:0], 1'b0};
					ne = ne - 11'sd1;
				end
			end
			if (sig == 8'd0) begin
				code = 8'd0;
			end else if (ne > 11'sd8) begin
				code = E4M3_MAX;
			end else if (ne >= -11'sd6) begin
				// normal: value = nsig/128 * 2^ne
				rm = nsig[3:0];
				nc = {1'b0, 4'(ne + 11'sd7), nsig[6:4]};
				if (rm > 4'd8 || (rm == 4'd8 && nc[0])) nc = nc + 9'd1;
				code = (nc > {1'b0, E4M3_MAX}) ? E4M3_MAX : nc[7:0];
			end else begin
				// e4m3 subnormal: units of 2^-9, value = nsig * 2^(ne+2)
				sh = 11'(-11'sd2 - ne);
				if (sh > 11'd20) begin
					code = 8'd0;
				end else begin
					wide = {nsig, 15'd0} >> sh[4:0];
					code = wide[22:15];
					rem = {8'd0, wide[14:0]};
					half = 23'h4000;
					if (rem > half || (rem == half && code[0])) code = code + 8'd1;
				end
			end
			quantise = {sgn, code[6:0]};
		end
	endfunction
endpackage
`default_nettype wire

FILE: design/mxfp8_block_quantizer.sv
// mxfp8 block quantiser top level: block store memory, max tracking and emission
// depends on mxq_pkg
//
// channel | dir | fields
// s_axis  | in  | tdata[15:0] value_bits
// m_axis  | out | tdata[7:0] fp8_code, tdata[15:8] scale_code, tlast block_end
//
// loading takes one value per cycle; emission one result per cycle through the memory read port
// while m_axis is not stalled; input stalls during emission.
// asynchronous reset clears counters and the maximum; the store needs no clearing.
// output register decouples m_axis_tready; a stalled result holds.
`timescale 1ns / 1ps
`default_nettype none
module mxfp8_block_quantizer import mxq_pkg::*; #(
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // value_bits
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // fp8_code, scale_code
	output logic             m_axis_tlast   // block_end
);
	localparam int AW = $clog2(BLOCK_SIZE);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	logic [15:0] mem [BLOCK_SIZE];
	logic [AW:0] cnt_q;
	logic [AW:0] rd_q;
	logic [14:0] max_q;
	logic [7:0] scale_q;
	logic [15:0] rdata_s1;
	logic v_s1;
	logic last_s1;
	logic out_free;
	logic issue;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign out_free = !m_axis_tvalid || m_axis_tready;
	// issue a read only if the output can take the pending one
	assign issue = (state_q == ST_EMIT) && (rd_q < (AW+1)'(BLOCK_SIZE))
		&& (!v_s1 || out_free) && out_free;

	// block store
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) mem[cnt_q[AW-1:0]] <= s_axis_tdata;
		if (issue) rdata_s1 <= mem[rd_q[AW-1:0]];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			rd_q <= '0;
			max_q <= '0;
			scale_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_axis_tvalid) begin
						if (s_axis_tdata[14:0] <= 15'h7F80 && s_axis_tdata[14:0] > max_q)
							max_q <= s_axis_tdata[14:0];
						if (cnt_q == (AW+1)'(BLOCK_SIZE - 1)) begin
							cnt_q <= '0;
							state_q <= ST_EMIT;
							rd_q <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					scale_q <= (max_q[14:7] > SCALE_MAX) ? SCALE_MAX : max_q[14:7];
					if (issue) rd_q <= rd_q + 1'b1;
					if (!issue && !v_s1 && rd_q == (AW+1)'(BLOCK_SIZE) && out_free) begin
						state_q <= ST_LOAD;
						max_q <= '0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			// read stage into output register
			if (out_free) m_axis_tvalid <= v_s1;
			if (issue) begin
				v_s1 <= 1'b1;
				last_s1 <= (rd_q == (AW+1)'(BLOCK_SIZE - 1));
			end else if (out_free) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			m_axis_tdata <= {scale_q, quantise(rdata_s1, scale_q)};
			m_axis_tlast <= last_s1;
		end
	end
endmodule
`default_nettype wire

FILE: design/mxq_checker.sv
// port-level checker for the mxfp8 block quantiser, bound to the top level
// depends on mxfp8_block_quantizer_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "mxfp8_block_quantizer_macros.svh"
module mxq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	// a stalled result stays offered and holds its payload
	`MXQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))
	// no input taken while results are being shown
	`MXQ_ASSERT_IMP(a_excl, m_axis_tvalid, !s_axis_tready)
	// shared exponent never exceeds 254
	`MXQ_ASSERT_IMP(a_scale, m_axis_tvalid, m_axis_tdata[15:8] != 8'hFF)
	// e4m3 nan code never produced
	`MXQ_ASSERT_IMP(a_nonan, m_axis_tvalid, m_axis_tdata[6:0] != 7'h7F)
endmodule
bind mxfp8_block_quantizer mxq_checker u_mxq_checker (.*);
`default_nettype wire
